@@ rtl/core/value_scan_candidate_filter_assert.svh @@
// assertion macros used by the checker file
// both macros expect signals named clk and rst_n in the enclosing scope
`ifndef VALUE_SCAN_CANDIDATE_FILTER_ASSERT_SVH
`define VALUE_SCAN_CANDIDATE_FILTER_ASSERT_SVH

// same-cycle implication
`define VSCF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vscf checker: property failed");

// next-cycle implication
`define VSCF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vscf checker: property failed");

`endif

@@ rtl/core/vscf_pkg.sv @@
// ----------------------------------------------------------------------------
// vscf_pkg
// shared constants, codes, types and compare helpers of the candidate filter
// ----------------------------------------------------------------------------
`default_nettype none

package vscf_pkg;

  localparam int CAPACITY  = 4096;
  localparam int IDX_BITS  = $clog2(CAPACITY);
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);
  localparam int ADDR_BITS = 48;
  localparam int VAL_BITS  = 64;
  localparam int FUNC_BITS = 3;
  localparam int MODE_BITS = 3;
  localparam int WC_BITS   = 2;
  localparam int STAT_BITS = 2;
  localparam int CFG_IDX_BITS = 2;

  // request functions
  localparam logic [FUNC_BITS-1:0] FN_SCAN   = 3'd0;
  localparam logic [FUNC_BITS-1:0] FN_REFINE = 3'd1;
  localparam logic [FUNC_BITS-1:0] FN_END    = 3'd2;
  localparam logic [FUNC_BITS-1:0] FN_CLEAR  = 3'd3;
  localparam logic [FUNC_BITS-1:0] FN_PEEK   = 3'd4;

  // compare modes
  localparam logic [MODE_BITS-1:0] MODE_EQ        = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_LT        = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_GT        = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_CHANGED   = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_UNCHANGED = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_INC       = 3'd5;
  localparam logic [MODE_BITS-1:0] MODE_DEC       = 3'd6;

  // width codes
  localparam logic [WC_BITS-1:0] WC_BYTE  = 2'd0;
  localparam logic [WC_BITS-1:0] WC_HALF  = 2'd1;
  localparam logic [WC_BITS-1:0] WC_WORD  = 2'd2;

  // result status
  localparam logic [STAT_BITS-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_NO_SCAN  = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_BAD_PEEK = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODE  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REF   = 2'd2;

  typedef struct packed {
    logic                 en;
    logic [IDX_BITS-1:0]  idx;
    logic [ADDR_BITS-1:0] addr;
    logic [VAL_BITS-1:0]  value;
  } tbl_wr_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic [VAL_BITS-1:0]  value;
  } tbl_entry_t;

  typedef struct packed {
    logic [STAT_BITS-1:0] status;
    logic                 matched;
    logic                 capped;
    logic [CNT_BITS-1:0]  entry_count;
    logic [ADDR_BITS-1:0] entry_address;
    logic [VAL_BITS-1:0]  entry_value;
  } rsp_t;

  function automatic logic [VAL_BITS-1:0] width_mask(input logic [WC_BITS-1:0] wc);
    logic [VAL_BITS-1:0] m;
    case (wc)
      WC_BYTE: m = VAL_BITS'(64'h0000_0000_0000_00FF);
      WC_HALF: m = VAL_BITS'(64'h0000_0000_0000_FFFF);
      WC_WORD: m = VAL_BITS'(64'h0000_0000_FFFF_FFFF);
      default: m = '1;
    endcase
    return m;
  endfunction

  function automatic logic value_match(input logic [MODE_BITS-1:0] mode,
                                       input logic [VAL_BITS-1:0]  v,
                                       input logic [VAL_BITS-1:0]  prev,
                                       input logic [VAL_BITS-1:0]  ref_val);
    logic hit;
    case (mode)
      MODE_EQ:        hit = (v == ref_val);
      MODE_LT:        hit = (v < ref_val);
      MODE_GT:        hit = (v > ref_val);
      MODE_CHANGED:   hit = (v != prev);
      MODE_UNCHANGED: hit = (v == prev);
      MODE_INC:       hit = (v > prev);
      MODE_DEC:       hit = (v < prev);
      default:        hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/vscf_req_if.sv @@
// ----------------------------------------------------------------------------
// vscf_req_if
// request channel of the candidate filter: valid, ready and request payload
// ----------------------------------------------------------------------------
`default_nettype none

interface vscf_req_if;
  logic                                valid;
  logic                                ready;
  logic [vscf_pkg::FUNC_BITS-1:0]      func;
  logic [vscf_pkg::ADDR_BITS-1:0]      address;
  logic [vscf_pkg::VAL_BITS-1:0]       data_word;
  logic                                read_ok;
  logic [vscf_pkg::IDX_BITS-1:0]       peek_index;

  modport source (output valid, func, address, data_word, read_ok, peek_index,
                  input ready);
  modport sink   (input valid, func, address, data_word, read_ok, peek_index,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/vscf_rsp_if.sv @@
// ----------------------------------------------------------------------------
// vscf_rsp_if
// result channel of the candidate filter: valid, ready and result payload
// ----------------------------------------------------------------------------
`default_nettype none

interface vscf_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [vscf_pkg::STAT_BITS-1:0]      status;
  logic                                matched;
  logic                                capped;
  logic [vscf_pkg::CNT_BITS-1:0]       entry_count;
  logic [vscf_pkg::ADDR_BITS-1:0]      entry_address;
  logic [vscf_pkg::VAL_BITS-1:0]       entry_value;

  modport source (output valid, status, matched, capped, entry_count, entry_address,
                  entry_value, input ready);
  modport sink   (input valid, status, matched, capped, entry_count, entry_address,
                  entry_value, output ready);
endinterface

`default_nettype wire

@@ rtl/core/value_scan_candidate_filter.sv @@
// ----------------------------------------------------------------------------
// value_scan_candidate_filter
// value-scan filter that builds and refines a table of address/value candidates
// ----------------------------------------------------------------------------
// Scan requests mask data_word to the configured width, compare it (equal,
// less, greater than reference_value, or the change modes against zero) and
// append matches until the table holds CAPACITY entries; after that capped is
// raised and scans are ignored until end or clear. Refine requests arrive in
// candidate order with re-read values; kept candidates are compacted in place
// and end commits the kept count. Peek returns one entry. Scan, end, clear and
// unknown functions answer from the idle state; refine (with a candidate left)
// and peek (in range) first wait in the exec state for the registered table
// read. A result waits in an output register, so the next request is taken no
// earlier than the cycle its predecessor's result is consumed. Table contents
// are not cleared after reset: only entries below the count are ever read.
// Configuration indexes beyond reference_value are ignored; the user writes
// cfg_we/cfg_index/cfg_data only while idle, which the block does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module value_scan_candidate_filter (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  vscf_req_if.sink                                in_req,
  vscf_rsp_if.source                              out_rsp,
  input  wire logic                               cfg_we,
  input  wire logic [vscf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [vscf_pkg::VAL_BITS-1:0]      cfg_data
);

  // one-hot sequencer: idle takes requests, exec finishes a table read
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [vscf_pkg::WC_BITS-1:0]   width_code_r;
  logic [vscf_pkg::MODE_BITS-1:0] mode_r;
  logic [vscf_pkg::VAL_BITS-1:0]  ref_r;

  // table bookkeeping
  logic [vscf_pkg::CNT_BITS-1:0] count_r, count_nxt;
  logic [vscf_pkg::CNT_BITS-1:0] rptr_r, rptr_nxt;
  logic [vscf_pkg::CNT_BITS-1:0] kept_r, kept_nxt;
  logic                          capped_r, capped_nxt;
  logic                          has_res_r, has_res_nxt;

  // request held across the table read
  logic                          op_peek_r, op_peek_nxt;
  logic                          op_rok_r, op_rok_nxt;
  logic [vscf_pkg::VAL_BITS-1:0] op_word_r, op_word_nxt;

  // output register
  logic            out_valid_r, out_valid_nxt;
  vscf_pkg::rsp_t  rsp_r, rsp_nxt;

  // table ports
  vscf_pkg::tbl_wr_t             tbl_wr;
  logic [vscf_pkg::IDX_BITS-1:0] tbl_rd_idx;
  vscf_pkg::tbl_entry_t          tbl_rd;

  logic                          in_ready;
  logic                          in_fire;
  logic [vscf_pkg::VAL_BITS-1:0] in_word;
  logic                          scan_hit;
  logic                          keep;

  vscf_table u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd_idx  (tbl_rd_idx),
    .rd_data (tbl_rd)
  );

  // take a request only when idle and the output slot is free or draining
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_rsp.ready);
  assign in_fire  = in_req.valid && in_ready;
  assign in_word  = in_req.data_word & vscf_pkg::width_mask(width_code_r);

  // change modes have no previous value in a scan, so they see zero
  assign scan_hit = vscf_pkg::value_match(mode_r, in_word, '0, ref_r);

  // refine keep decision, judged against the stored last value
  assign keep = op_rok_r && vscf_pkg::value_match(mode_r, op_word_r, tbl_rd.value, ref_r)
                && (kept_r < vscf_pkg::CNT_BITS'(vscf_pkg::CAPACITY));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rptr_nxt      = rptr_r;
    kept_nxt      = kept_r;
    capped_nxt    = capped_r;
    has_res_nxt   = has_res_r;
    op_peek_nxt   = op_peek_r;
    op_rok_nxt    = op_rok_r;
    op_word_nxt   = op_word_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    rsp_nxt       = rsp_r;
    tbl_wr        = '0;
    tbl_rd_idx    = rptr_r[vscf_pkg::IDX_BITS-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          rsp_nxt       = '0;
          out_valid_nxt = 1'b1;
          case (in_req.func)
            vscf_pkg::FN_SCAN: begin
              has_res_nxt = 1'b1;
              if (!capped_r && scan_hit) begin
                if (count_r >= vscf_pkg::CNT_BITS'(vscf_pkg::CAPACITY)) begin
                  // full: remember the overflow, drop the match
                  capped_nxt = 1'b1;
                end else begin
                  tbl_wr.en             = 1'b1;
                  tbl_wr.idx            = count_r[vscf_pkg::IDX_BITS-1:0];
                  tbl_wr.addr           = in_req.address;
                  tbl_wr.value          = in_word;
                  count_nxt             = count_r + vscf_pkg::CNT_BITS'(1);
                  rsp_nxt.matched       = 1'b1;
                  rsp_nxt.entry_address = in_req.address;
                  rsp_nxt.entry_value   = in_word;
                end
              end
              rsp_nxt.entry_count = count_nxt;
            end
            vscf_pkg::FN_REFINE: begin
              rsp_nxt.entry_count = kept_r;
              if (!has_res_r) begin
                rsp_nxt.status = vscf_pkg::ST_NO_SCAN;
              end else if (rptr_r < count_r) begin
                // fetch the candidate, finish next cycle
                out_valid_nxt = 1'b0;
                op_peek_nxt   = 1'b0;
                op_rok_nxt    = in_req.read_ok;
                op_word_nxt   = in_word;
                state_nxt     = S_EXEC;
              end
            end
            vscf_pkg::FN_END: begin
              if (!has_res_r) begin
                rsp_nxt.status = vscf_pkg::ST_NO_SCAN;
              end else begin
                count_nxt  = kept_r;
                rptr_nxt   = '0;
                kept_nxt   = '0;
                capped_nxt = 1'b0;
              end
              rsp_nxt.entry_count = count_nxt;
            end
            vscf_pkg::FN_CLEAR: begin
              count_nxt   = '0;
              rptr_nxt    = '0;
              kept_nxt    = '0;
              capped_nxt  = 1'b0;
              has_res_nxt = 1'b0;
            end
            vscf_pkg::FN_PEEK: begin
              rsp_nxt.entry_count = count_r;
              if ({1'b0, in_req.peek_index} < count_r) begin
                tbl_rd_idx    = in_req.peek_index;
                out_valid_nxt = 1'b0;
                op_peek_nxt   = 1'b1;
                state_nxt     = S_EXEC;
              end else begin
                rsp_nxt.status = vscf_pkg::ST_BAD_PEEK;
              end
            end
            default: begin
              rsp_nxt.entry_count = count_r;
            end
          endcase
          rsp_nxt.capped = capped_nxt;
        end
      end

      S_EXEC: begin
        // table read data is valid now; output slot is known to be empty
        out_valid_nxt         = 1'b1;
        rsp_nxt               = '0;
        rsp_nxt.capped        = capped_r;
        rsp_nxt.entry_address = tbl_rd.addr;
        rsp_nxt.entry_value   = tbl_rd.value;
        if (op_peek_r) begin
          rsp_nxt.entry_count = count_r;
        end else begin
          if (keep) begin
            // compact in place with the fresh value
            tbl_wr.en           = 1'b1;
            tbl_wr.idx          = kept_r[vscf_pkg::IDX_BITS-1:0];
            tbl_wr.addr         = tbl_rd.addr;
            tbl_wr.value        = op_word_r;
            kept_nxt            = kept_r + vscf_pkg::CNT_BITS'(1);
            rsp_nxt.matched     = 1'b1;
            rsp_nxt.entry_value = op_word_r;
          end
          rptr_nxt            = rptr_r + vscf_pkg::CNT_BITS'(1);
          rsp_nxt.entry_count = kept_nxt;
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rptr_r      <= '0;
      kept_r      <= '0;
      capped_r    <= 1'b0;
      has_res_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rptr_r      <= rptr_nxt;
      kept_r      <= kept_nxt;
      capped_r    <= capped_nxt;
      has_res_r   <= has_res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    op_peek_r <= op_peek_nxt;
    op_rok_r  <= op_rok_nxt;
    op_word_r <= op_word_nxt;
    rsp_r     <= rsp_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_code_r <= vscf_pkg::WC_WORD;
      mode_r       <= vscf_pkg::MODE_EQ;
      ref_r        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        vscf_pkg::CFG_WIDTH: width_code_r <= cfg_data[vscf_pkg::WC_BITS-1:0];
        vscf_pkg::CFG_MODE:  mode_r       <= cfg_data[vscf_pkg::MODE_BITS-1:0];
        vscf_pkg::CFG_REF:   ref_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_req.ready          = in_ready;
  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = rsp_r.status;
  assign out_rsp.matched       = rsp_r.matched;
  assign out_rsp.capped        = rsp_r.capped;
  assign out_rsp.entry_count   = rsp_r.entry_count;
  assign out_rsp.entry_address = rsp_r.entry_address;
  assign out_rsp.entry_value   = rsp_r.entry_value;

endmodule

`default_nettype wire

@@ rtl/core/vscf_table.sv @@
// ----------------------------------------------------------------------------
// vscf_table
// candidate table: address and last-value memories, one write, one registered read
// ----------------------------------------------------------------------------
`default_nettype none

module vscf_table (
  input  wire logic                          clk,
  input  wire vscf_pkg::tbl_wr_t             wr,
  input  wire logic [vscf_pkg::IDX_BITS-1:0] rd_idx,
  output vscf_pkg::tbl_entry_t               rd_data
);

  logic [vscf_pkg::ADDR_BITS-1:0] addr_mem [vscf_pkg::CAPACITY];
  logic [vscf_pkg::VAL_BITS-1:0]  val_mem  [vscf_pkg::CAPACITY];
  vscf_pkg::tbl_entry_t           rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      addr_mem[wr.idx] <= wr.addr;
      val_mem[wr.idx]  <= wr.value;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r.addr  <= addr_mem[rd_idx];
    rd_data_r.value <= val_mem[rd_idx];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/core/vscf_checker.sv @@
// ----------------------------------------------------------------------------
// vscf_checker
// port-level checks on the candidate filter's result channel
// ----------------------------------------------------------------------------
`default_nettype none

`include "value_scan_candidate_filter_assert.svh"

module vscf_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic [vscf_pkg::STAT_BITS-1:0]     out_status,
  input wire logic                               out_matched,
  input wire logic [vscf_pkg::CNT_BITS-1:0]      out_entry_count,
  input wire logic [vscf_pkg::ADDR_BITS-1:0]     out_entry_address,
  input wire logic [vscf_pkg::VAL_BITS-1:0]      out_entry_value
);

  // a result stays up until it is taken
  `VSCF_ASSERT_NEXT(a_rsp_hold, out_valid && !out_ready, out_valid)

  // a kept or appended candidate never carries an error status
  `VSCF_ASSERT_NOW(a_match_ok, out_valid && out_matched, out_status == vscf_pkg::ST_OK)

  // out-of-range peek returns an empty entry
  `VSCF_ASSERT_NOW(a_bad_peek_empty, out_valid && out_status == vscf_pkg::ST_BAD_PEEK,
    !out_matched && out_entry_address == '0 && out_entry_value == '0)

  // count never exceeds the table size
  `VSCF_ASSERT_NOW(a_count_cap, out_valid,
    out_entry_count <= vscf_pkg::CNT_BITS'(vscf_pkg::CAPACITY))

endmodule

bind value_scan_candidate_filter vscf_checker u_vscf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_rsp.valid),
  .out_ready         (out_rsp.ready),
  .out_status        (out_rsp.status),
  .out_matched       (out_rsp.matched),
  .out_entry_count   (out_rsp.entry_count),
  .out_entry_address (out_rsp.entry_address),
  .out_entry_value   (out_rsp.entry_value)
);

`default_nettype wire

@@ tb/tb_value_scan_candidate_filter.sv @@
// ----------------------------------------------------------------------------
// tb_value_scan_candidate_filter
// self-checking bench for the value-scan candidate filter
// ----------------------------------------------------------------------------
// Requests go in over the request channel with random gaps, and results are
// taken with random back-pressure. A mirror of the candidate table predicts
// every result from the accepted requests and checks each one in order. After
// a short directed opening, a set of scan/refine/end sessions walks every
// width and compare mode, followed by random sessions with a little noise
// mixed in.
// ----------------------------------------------------------------------------
module tb_value_scan_candidate_filter;
  timeunit 1ns;
  timeprecision 1ps;

  import vscf_pkg::*;

  // codes the package leaves out
  localparam logic [FUNC_BITS-1:0]    FN_UNUSED_LO = 3'd5;
  localparam logic [FUNC_BITS-1:0]    FN_UNUSED_HI = 3'd7;
  localparam logic [MODE_BITS-1:0]    MODE_NONE    = 3'd7;
  localparam logic [WC_BITS-1:0]      WC_DWORD     = 2'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE    = 2'd3;

  localparam int RANDOM_ITEMS = 330;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int STALL_LIMIT  = 2000;  // cycles with no handshake at all
  localparam int SETTLE_WAIT  = 4;
  localparam int END_WAIT     = 8;

  typedef struct packed {
    logic [FUNC_BITS-1:0] func;
    logic [ADDR_BITS-1:0] address;
    logic [VAL_BITS-1:0]  data_word;
    logic                 read_ok;
    logic [IDX_BITS-1:0]  peek_index;
  } scan_req_t;

  // mirror of the candidate table: predicts one result per request
  class candidate_table_mirror;
    logic [ADDR_BITS-1:0] addr_mem  [CAPACITY];
    logic [VAL_BITS-1:0]  value_mem [CAPACITY];
    logic [CNT_BITS-1:0]  entries;
    logic [CNT_BITS-1:0]  cursor;
    logic [CNT_BITS-1:0]  kept;
    logic                 capped;
    logic                 scanned;
    logic [WC_BITS-1:0]   width_sel;
    logic [MODE_BITS-1:0] mode;
    logic [VAL_BITS-1:0]  ref_word;
    rsp_t                 pending_results[$];
    int                   errors;

    function new();
      entries   = '0;
      cursor    = '0;
      kept      = '0;
      capped    = 1'b0;
      scanned   = 1'b0;
      width_sel = WC_WORD;
      mode      = MODE_EQ;
      ref_word  = '0;
      errors    = 0;
    endfunction

    function void set_config(input logic [WC_BITS-1:0] wc, input logic [MODE_BITS-1:0] m,
                             input logic [VAL_BITS-1:0] rv);
      width_sel = wc;
      mode      = m;
      ref_word  = rv;
    endfunction

    function logic [VAL_BITS-1:0] lane_mask();
      case (width_sel)
        WC_BYTE: return 64'h0000_0000_0000_00FF;
        WC_HALF: return 64'h0000_0000_0000_FFFF;
        WC_WORD: return 64'h0000_0000_FFFF_FFFF;
        default: return '1;
      endcase
    endfunction

    function logic hits(input logic [VAL_BITS-1:0] v, input logic [VAL_BITS-1:0] prev);
      case (mode)
        MODE_EQ:        return v == ref_word;
        MODE_LT:        return v < ref_word;
        MODE_GT:        return v > ref_word;
        MODE_CHANGED:   return v != prev;
        MODE_UNCHANGED: return v == prev;
        MODE_INC:       return v > prev;
        MODE_DEC:       return v < prev;
        default:        return 1'b0;
      endcase
    endfunction

    function void note_request(input scan_req_t r);
      rsp_t                e;
      logic [VAL_BITS-1:0] w;
      logic [IDX_BITS-1:0] slot;
      e = '0;
      w = r.data_word & lane_mask();
      e.entry_count = entries;
      case (r.func)
        FN_SCAN: begin
          scanned = 1'b1;
          // the first pass compares change modes against zero
          if (!capped && hits(w, '0)) begin
            if (entries >= CAPACITY) begin
              capped = 1'b1;
            end else begin
              addr_mem[entries[IDX_BITS-1:0]]  = r.address;
              value_mem[entries[IDX_BITS-1:0]] = w;
              entries++;
              e.matched       = 1'b1;
              e.entry_address = r.address;
              e.entry_value   = w;
            end
          end
          e.entry_count = entries;
        end
        FN_REFINE: begin
          if (!scanned) begin
            e.status = ST_NO_SCAN;
          end else if (cursor < entries) begin
            slot            = cursor[IDX_BITS-1:0];
            e.entry_address = addr_mem[slot];
            e.entry_value   = value_mem[slot];
            if (r.read_ok && hits(w, value_mem[slot]) && kept < CAPACITY) begin
              addr_mem[kept[IDX_BITS-1:0]]  = e.entry_address;
              value_mem[kept[IDX_BITS-1:0]] = w;
              kept++;
              e.matched     = 1'b1;
              e.entry_value = w;
            end
            cursor++;
          end
          e.entry_count = kept;
        end
        FN_END: begin
          if (!scanned) begin
            e.status = ST_NO_SCAN;
          end else begin
            entries = kept;
            cursor  = '0;
            kept    = '0;
            capped  = 1'b0;
          end
          e.entry_count = entries;
        end
        FN_CLEAR: begin
          entries       = '0;
          cursor        = '0;
          kept          = '0;
          capped        = 1'b0;
          scanned       = 1'b0;
          e.entry_count = '0;
        end
        FN_PEEK: begin
          if (r.peek_index < entries) begin
            e.entry_address = addr_mem[r.peek_index];
            e.entry_value   = value_mem[r.peek_index];
          end else begin
            e.status = ST_BAD_PEEK;
          end
        end
        default: ;
      endcase
      e.capped = capped;
      pending_results.push_back(e);
    endfunction

    function void compare_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_response(input rsp_t got);
      rsp_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: expected nothing, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("matched", want.matched, got.matched);
      compare_field("capped", want.capped, got.capped);
      compare_field("entry_count", want.entry_count, got.entry_count);
      compare_field("entry_address", want.entry_address, got.entry_address);
      compare_field("entry_value", want.entry_value, got.entry_value);
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [VAL_BITS-1:0]     cfg_data;

  vscf_req_if req_ch();
  vscf_rsp_if rsp_ch();

  candidate_table_mirror mirror = new();

  // idling switches and the hold-off trigger, shared with the result side
  logic sender_idle_on   = 1'b1;
  logic receiver_idle_on = 1'b1;
  logic hold_request     = 1'b0;
  int   items_sent       = 0;

  value_scan_candidate_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_ch),
    .out_rsp   (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // request with every field random and the function given
  function automatic scan_req_t request(input logic [FUNC_BITS-1:0] f);
    scan_req_t r;
    r.func       = f;
    r.address    = ADDR_BITS'({$urandom, $urandom});
    r.data_word  = {$urandom, $urandom};
    r.read_ok    = 1'($urandom_range(0, 1));
    r.peek_index = IDX_BITS'($urandom);
    return r;
  endfunction

  // noise: any function code, known or not
  function automatic scan_req_t random_request();
    return request(FUNC_BITS'($urandom_range(0, 7)));
  endfunction

  // word that lands near the interesting compare points, with junk above the lane
  function automatic logic [VAL_BITS-1:0] craft_word(input logic [VAL_BITS-1:0] prev);
    logic [VAL_BITS-1:0] lane;
    logic [VAL_BITS-1:0] pick;
    lane = mirror.lane_mask();
    case ($urandom_range(0, 8))
      0: pick = prev;
      1: pick = prev + 1;
      2: pick = prev - 1;
      3: pick = mirror.ref_word;
      4: pick = mirror.ref_word + 1;
      5: pick = mirror.ref_word - 1;
      6: pick = '0;
      7: pick = '1;
      default: pick = {$urandom, $urandom};
    endcase
    return (pick & lane) | ({$urandom, $urandom} & ~lane);
  endfunction

  // last value of the candidate the next refine will meet
  function automatic logic [VAL_BITS-1:0] next_candidate_value();
    if (mirror.cursor < mirror.entries)
      return mirror.value_mem[mirror.cursor[IDX_BITS-1:0]];
    return '0;
  endfunction

  // offer one request and wait for the handshake; valid stays up for the next one
  task automatic send_request(input scan_req_t r);
    while (sender_idle_on && $urandom_range(99) < 37) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.func       <= r.func;
    req_ch.address    <= r.address;
    req_ch.data_word  <= r.data_word;
    req_ch.read_ok    <= r.read_ok;
    req_ch.peek_index <= r.peek_index;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    mirror.note_request(r);
    items_sent++;
  endtask

  // stop offering and wait until every result is back
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (mirror.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // all registers in back-to-back writes, plus the unused index; block is idle
  task automatic configure(input logic [WC_BITS-1:0] wc, input logic [MODE_BITS-1:0] m,
                           input logic [VAL_BITS-1:0] rv);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WIDTH;
    cfg_data  <= VAL_BITS'(wc);
    @(posedge clk);
    cfg_index <= CFG_MODE;
    cfg_data  <= VAL_BITS'(m);
    @(posedge clk);
    cfg_index <= CFG_REF;
    cfg_data  <= rv;
    @(posedge clk);
    // unused index must leave everything alone
    cfg_index <= CFG_SPARE;
    cfg_data  <= {$urandom, $urandom};
    @(posedge clk);
    cfg_we <= 1'b0;
    mirror.set_config(wc, m, rv);
  endtask

  // scan, refine under a possibly different mode, end, then a few peeks
  task automatic run_session(input int scans, input logic [WC_BITS-1:0] wc,
                             input logic [MODE_BITS-1:0] scan_mode,
                             input logic [MODE_BITS-1:0] refine_mode,
                             input logic [VAL_BITS-1:0] rv);
    scan_req_t r;
    int        passes;
    configure(wc, scan_mode, rv);
    send_request(request(FN_CLEAR));
    repeat (scans) begin
      if ($urandom_range(99) < 6) begin
        r = random_request();
      end else begin
        r = request(FN_SCAN);
        r.data_word = craft_word('0);
      end
      send_request(r);
    end
    settle();
    configure(wc, refine_mode, rv);
    // sometimes walk past the last candidate
    passes = mirror.entries + $urandom_range(0, 2);
    repeat (passes) begin
      if ($urandom_range(99) < 6) begin
        r = random_request();
      end else begin
        r = request(FN_REFINE);
        r.read_ok   = ($urandom_range(99) < 88);
        r.data_word = craft_word(next_candidate_value());
      end
      send_request(r);
    end
    // a broken sequence now and then: no end
    if ($urandom_range(99) < 90) send_request(request(FN_END));
    repeat (3) begin
      r = request(FN_PEEK);
      if (mirror.entries != 0 && $urandom_range(99) < 75)
        r.peek_index = IDX_BITS'($urandom_range(0, mirror.entries - 1));
      send_request(r);
    end
    settle();
  endtask

  // result side: check accepted results, then pick ready for the next cycle
  initial begin : result_side
    rsp_t got;
    int   hold_left;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
        got.status        = rsp_ch.status;
        got.matched       = rsp_ch.matched;
        got.capped        = rsp_ch.capped;
        got.entry_count   = rsp_ch.entry_count;
        got.entry_address = rsp_ch.entry_address;
        got.entry_value   = rsp_ch.entry_value;
        mirror.check_response(got);
      end
      // long hold-off so the block backs up into the request side
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= !(receiver_idle_on && $urandom_range(99) < 37);
      end
    end
  end

  // watchdog: too long without any handshake ends the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    scan_req_t               r;
    int                      base;
    logic                    hold_done;
    logic [WC_BITS-1:0]      wc;
    logic [MODE_BITS-1:0]    sm;
    logic [MODE_BITS-1:0]    rm;
    logic [VAL_BITS-1:0]     rv;
    hold_done         = 1'b0;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.func       <= '0;
    req_ch.address    <= '0;
    req_ch.data_word  <= '0;
    req_ch.read_ok    <= 1'b0;
    req_ch.peek_index <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed opening under reset config: 4-byte width, equal to zero
    // refine and end before any scan are refused
    send_request(request(FN_REFINE));
    send_request(request(FN_END));
    // peek on an empty table
    r = request(FN_PEEK);
    r.peek_index = '0;
    send_request(r);
    // unknown function codes
    for (int f = FN_UNUSED_LO; f <= FN_UNUSED_HI; f++) send_request(request(FUNC_BITS'(f)));
    // bytes above the lane do not count: the first and last of these scans match zero
    r = request(FN_SCAN);
    r.address   = '0;
    r.data_word = 64'hFFFF_FFFF_0000_0000;
    send_request(r);
    r.address   = '1;
    r.data_word = '1;
    send_request(r);
    r.data_word = 64'hA5A5_A5A5_0000_0000;
    send_request(r);
    // peeks in range and at the top index
    r = request(FN_PEEK);
    r.peek_index = '0;
    send_request(r);
    r.peek_index = IDX_BITS'(1);
    send_request(r);
    r.peek_index = '1;
    send_request(r);
    // failed re-read drops, a matching one keeps, then past the last one
    r = request(FN_REFINE);
    r.read_ok = 1'b0;
    send_request(r);
    r.read_ok   = 1'b1;
    r.data_word = 64'h1234_5678_0000_0000;
    send_request(r);
    send_request(r);
    send_request(request(FN_END));
    r = request(FN_PEEK);
    r.peek_index = '0;
    send_request(r);
    // clear empties and forgets the scan
    send_request(request(FN_CLEAR));
    send_request(r);
    send_request(request(FN_REFINE));
    settle();

    // every width and compare mode at least once, reference at both extremes
    run_session(12, WC_BYTE,  MODE_EQ,        MODE_CHANGED,   64'h0000_0000_0000_005C);
    run_session(12, WC_HALF,  MODE_LT,        MODE_UNCHANGED, 64'h0000_0000_0000_8000);
    run_session(12, WC_WORD,  MODE_GT,        MODE_INC,       '0);
    run_session(12, WC_DWORD, MODE_CHANGED,   MODE_DEC,       '1);
    run_session(12, WC_DWORD, MODE_UNCHANGED, MODE_EQ,        {$urandom, $urandom});
    run_session(12, WC_BYTE,  MODE_INC,       MODE_GT,        64'h0000_0000_0000_0080);
    run_session(12, WC_HALF,  MODE_DEC,       MODE_LT,        64'h0000_0000_0000_1000);
    run_session(12, WC_WORD,  MODE_NONE,      MODE_NONE,      '0);

    // random sessions; one runs without idling and with the long hold-off
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      wc = WC_BITS'($urandom_range(0, 3));
      sm = ($urandom_range(0, 14) == 0) ? MODE_NONE : MODE_BITS'($urandom_range(0, 6));
      rm = ($urandom_range(0, 14) == 0) ? MODE_NONE : MODE_BITS'($urandom_range(0, 6));
      case ($urandom_range(0, 9))
        0:       rv = '0;
        1:       rv = '1;
        default: rv = {$urandom, $urandom} >> (8 * $urandom_range(0, 7));
      endcase
      if (items_sent - base > RANDOM_ITEMS / 3 && !hold_done) begin
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        hold_request     = 1'b1;
        run_session(60, wc, sm, rm, rv);
        sender_idle_on   = 1'b1;
        receiver_idle_on = 1'b1;
        hold_done        = 1'b1;
      end else begin
        run_session($urandom_range(4, 40), wc, sm, rm, rv);
      end
    end

    settle();
    repeat (END_WAIT) @(posedge clk);
    if (mirror.errors == 0 && mirror.pending_results.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule

@@ value_scan_candidate_filter.f @@
+incdir+rtl/core
rtl/core/vscf_pkg.sv
rtl/core/vscf_req_if.sv
rtl/core/vscf_rsp_if.sv
rtl/core/vscf_table.sv
rtl/core/value_scan_candidate_filter.sv
rtl/core/vscf_checker.sv
tb/tb_value_scan_candidate_filter.sv
